[hdl/efg_pkg.sv]
package efg_pkg;

    localparam logic [2:0] CMD_TEST   = 3'd0;
    localparam logic [2:0] CMD_SET    = 3'd1;
    localparam logic [2:0] CMD_CLEAR  = 3'd2;
    localparam logic [2:0] CMD_TOGGLE = 3'd3;
    localparam logic [2:0] CMD_CANCEL = 3'd4;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] mask;
        logic        match_all;
        logic        clear_on_match;
        logic        may_wait;
        logic [3:0]  task_id;
    } req_t;

    typedef struct packed {
        logic [31:0] flags_before;
        logic        satisfied;
        logic        queued;
        logic        woken_valid;
        logic [3:0]  woken_task;
        logic        last;
    } res_t;

    typedef struct packed {
        logic wr;
        logic clr;
        logic rd;
    } tbl_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

endpackage

[hdl/efg_cond.sv]
module efg_cond #(
    parameter int FLAG_BITS = 32
) (
    input  logic [FLAG_BITS-1:0] flags,
    input  logic [FLAG_BITS-1:0] mask,
    input  logic                 match_all,
    output logic                 hold
);

    logic [FLAG_BITS-1:0] hit;

    assign hit  = flags & mask;
    assign hold = match_all ? (hit == mask) : (|hit);

endmodule

[hdl/efg_waiter_table.sv]
module efg_waiter_table import efg_pkg::*; #(
    parameter int WAITER_SLOTS = 16,
    parameter int FLAG_BITS    = 32,
    parameter int IDX_W        = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tbl_ctrl_t            ctrl,
    input  logic [IDX_W-1:0]     wr_idx,
    input  logic [FLAG_BITS-1:0] wr_mask,
    input  logic                 wr_all,
    input  logic [IDX_W-1:0]     clr_idx,
    input  logic [IDX_W-1:0]     rd_idx,
    output logic                 rd_valid,
    output logic [FLAG_BITS-1:0] rd_mask,
    output logic                 rd_all
);

    logic [FLAG_BITS:0]    entry_mem [WAITER_SLOTS];
    logic [FLAG_BITS:0]    rd_data_reg;
    logic [WAITER_SLOTS-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr)
        begin
            entry_mem[wr_idx] <= {wr_all, wr_mask};
        end
        if (ctrl.rd)
        begin
            rd_data_reg <= entry_mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ctrl.wr)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (ctrl.clr)
            begin
                valid_reg[clr_idx] <= 1'b0;
            end
        end
    end

    assign rd_valid = valid_reg[rd_idx];
    assign rd_mask  = rd_data_reg[FLAG_BITS-1:0];
    assign rd_all   = rd_data_reg[FLAG_BITS];

endmodule

[hdl/event_flag_group_waiter_wake.sv]
// Event flag group with one waiter slot per task. A request is taken when start is high
// and busy is low. Test, clear, cancel and unknown commands give one result, registered
// out of the execute state, and the next request can be taken while it is shown. Set and
// toggle update the flags and then scan every slot in ascending order through the
// single condition checker, each slot by a registered read of the waiter memory, then
// the compare. Such a request holds busy high until the scan and its final result state
// are done, and it gives one result per released waiter, or one result with woken_valid
// low if none is released. Each result is marked by strobe for exactly one cycle; the
// receiver cannot stall it, so it must take every result as it appears.
module event_flag_group_waiter_wake import efg_pkg::*; #(
    parameter int WAITER_SLOTS = 16,
    parameter int FLAG_BITS    = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t request,
    output logic busy,
    output logic strobe,
    output res_t result
);

    localparam int IDX_W = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
    localparam int EXT_W = (FLAG_BITS > 32) ? FLAG_BITS : 32;
    localparam int IXE_W = (IDX_W > 4) ? IDX_W : 4;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WAITER_SLOTS - 1);

    state_t               state_reg, state_next;
    req_t                 req_reg;
    logic [FLAG_BITS-1:0] flag_reg, flag_next;
    logic [31:0]          before_reg, before_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic                 strobe_reg, strobe_next;
    res_t                 result_reg, result_next;

    logic [EXT_W-1:0]     mask_ext;
    logic [FLAG_BITS-1:0] req_mask;
    logic [EXT_W-1:0]     flag_ext;
    logic [31:0]          flag_low;
    logic [IXE_W-1:0]     tid_ext;
    logic [IDX_W-1:0]     tid_idx;
    logic                 tid_ok;
    logic [IXE_W-1:0]     pend_ext;

    tbl_ctrl_t            tbl_ctrl;
    logic [IDX_W-1:0]     clr_idx;
    logic                 rd_valid;
    logic [FLAG_BITS-1:0] rd_mask;
    logic                 rd_all;

    logic [FLAG_BITS-1:0] cond_mask;
    logic                 cond_all;
    logic                 cond_hold;

    // width fitting of the request fields
    assign mask_ext = EXT_W'(req_reg.mask);
    assign req_mask = mask_ext[FLAG_BITS-1:0];
    assign flag_ext = EXT_W'(flag_reg);
    assign flag_low = flag_ext[31:0];
    assign tid_ext  = IXE_W'(req_reg.task_id);
    assign tid_idx  = tid_ext[IDX_W-1:0];
    assign tid_ok   = (7'(req_reg.task_id) < 7'(WAITER_SLOTS));
    assign pend_ext = IXE_W'(pend_idx_reg);

    // shared condition checker
    assign cond_mask = (state_reg == ST_EXEC) ? req_mask : rd_mask;
    assign cond_all  = (state_reg == ST_EXEC) ? req_reg.match_all : rd_all;

    efg_cond #(
        .FLAG_BITS (FLAG_BITS)
    ) u_cond (
        .flags     (flag_reg),
        .mask      (cond_mask),
        .match_all (cond_all),
        .hold      (cond_hold)
    );

    efg_waiter_table #(
        .WAITER_SLOTS (WAITER_SLOTS),
        .FLAG_BITS    (FLAG_BITS),
        .IDX_W        (IDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (tbl_ctrl),
        .wr_idx   (tid_idx),
        .wr_mask  (req_mask),
        .wr_all   (req_reg.match_all),
        .clr_idx  (clr_idx),
        .rd_idx   (idx_reg),
        .rd_valid (rd_valid),
        .rd_mask  (rd_mask),
        .rd_all   (rd_all)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (req_reg.command == CMD_SET || req_reg.command == CMD_TOGGLE)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        flag_next       = flag_reg;
        before_next     = before_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        strobe_next     = 1'b0;
        result_next     = result_reg;
        tbl_ctrl        = '0;
        clr_idx         = idx_reg;
        case (state_reg)
            ST_EXEC:
            begin
                before_next             = flag_low;
                idx_next                = '0;
                pend_valid_next         = 1'b0;
                result_next             = '0;
                result_next.flags_before = flag_low;
                result_next.last        = 1'b1;
                strobe_next             = 1'b1;
                case (req_reg.command)
                    CMD_TEST:
                    begin
                        result_next.satisfied = cond_hold;
                        if (cond_hold)
                        begin
                            if (req_reg.clear_on_match)
                            begin
                                flag_next = flag_reg & ~req_mask;
                            end
                        end
                        else if (req_reg.may_wait && tid_ok)
                        begin
                            tbl_ctrl.wr        = 1'b1;
                            result_next.queued = 1'b1;
                        end
                    end
                    CMD_SET:
                    begin
                        flag_next   = flag_reg | req_mask;
                        strobe_next = 1'b0;
                    end
                    CMD_TOGGLE:
                    begin
                        flag_next   = flag_reg ^ req_mask;
                        strobe_next = 1'b0;
                    end
                    CMD_CLEAR:
                    begin
                        flag_next = flag_reg & ~req_mask;
                    end
                    CMD_CANCEL:
                    begin
                        clr_idx      = tid_idx;
                        tbl_ctrl.clr = tid_ok;
                    end
                    default:
                    begin
                        flag_next = flag_reg;
                    end
                endcase
            end
            ST_READ:
            begin
                tbl_ctrl.rd = 1'b1;
            end
            ST_CHECK:
            begin
                if (idx_reg != LAST_IDX)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (rd_valid && cond_hold)
                begin
                    tbl_ctrl.clr = 1'b1;
                    // release the held waiter, keep this one back for the last mark
                    if (pend_valid_reg)
                    begin
                        result_next              = '0;
                        result_next.flags_before = before_reg;
                        result_next.woken_valid  = 1'b1;
                        result_next.woken_task   = pend_ext[3:0];
                        strobe_next              = 1'b1;
                    end
                    pend_valid_next = 1'b1;
                    pend_idx_next   = idx_reg;
                end
            end
            ST_DONE:
            begin
                result_next              = '0;
                result_next.flags_before = before_reg;
                result_next.woken_valid  = pend_valid_reg;
                result_next.woken_task   = pend_valid_reg ? pend_ext[3:0] : 4'd0;
                result_next.last         = 1'b1;
                strobe_next              = 1'b1;
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            flag_reg       <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            flag_reg       <= flag_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            req_reg <= request;
        end
        before_reg   <= before_next;
        pend_idx_reg <= pend_idx_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

[dv/event_flag_group_waiter_wake_test.sv]
module event_flag_group_waiter_wake_test;
    import efg_pkg::*;

    localparam logic [2:0] CMD_UNDEF_LO = 3'd5;
    localparam logic [2:0] CMD_UNDEF_HI = 3'd7;
    localparam int SLOTS = 16;
    localparam int RANDOM_REQUESTS = 445;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        req_t        req;
        int unsigned gap;
        bit          drain;
    } stim_item_t;

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t request = '0;
    logic busy;
    logic strobe;
    res_t result;

    stim_item_t request_backlog[$];
    res_t       results_due[$];
    int         fail_count = 0;
    int         idle_cycles = 0;

    // predictor state
    logic [31:0] flag_word = '0;
    bit          waiter_valid[SLOTS];
    logic [31:0] waiter_mask[SLOTS];
    bit          waiter_all[SLOTS];

    // driver state
    stim_item_t  now_item;
    bit          item_loaded = 1'b0;
    int unsigned gap_left = 0;

    event_flag_group_waiter_wake DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .request(request),
        .busy(busy),
        .strobe(strobe),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit condition_met(logic [31:0] flags, logic [31:0] m, bit all);
        if (all)
            return (flags & m) == m;
        return (flags & m) != '0;
    endfunction

    task automatic apply_flag_command(input req_t r);
        res_t out;
        res_t held;
        int   woken;
        out = '0;
        out.flags_before = flag_word;
        out.last = 1'b1;
        woken = 0;
        case (r.command)
            CMD_TEST:
            begin
                out.satisfied = condition_met(flag_word, r.mask, r.match_all);
                if (out.satisfied)
                begin
                    if (r.clear_on_match)
                        flag_word &= ~r.mask;
                end
                else if (r.may_wait)
                begin
                    waiter_valid[r.task_id] = 1'b1;
                    waiter_mask[r.task_id] = r.mask;
                    waiter_all[r.task_id] = r.match_all;
                    out.queued = 1'b1;
                end
                results_due.push_back(out);
            end
            CMD_SET, CMD_TOGGLE:
            begin
                if (r.command == CMD_SET)
                    flag_word |= r.mask;
                else
                    flag_word ^= r.mask;
                out.last = 1'b0;
                held = out;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (waiter_valid[i] && condition_met(flag_word, waiter_mask[i], waiter_all[i]))
                    begin
                        waiter_valid[i] = 1'b0;
                        if (woken > 0)
                            results_due.push_back(held);
                        held = out;
                        held.woken_valid = 1'b1;
                        held.woken_task = 4'(i);
                        woken++;
                    end
                end
                held.last = 1'b1;
                results_due.push_back(held);
            end
            CMD_CLEAR:
            begin
                flag_word &= ~r.mask;
                results_due.push_back(out);
            end
            CMD_CANCEL:
            begin
                waiter_valid[r.task_id] = 1'b0;
                results_due.push_back(out);
            end
            default:
                results_due.push_back(out);
        endcase
    endtask

    function automatic req_t make_req(logic [2:0] cmd, logic [31:0] m, bit all, bit clr,
                                      bit wait_on_miss, logic [3:0] tid);
        req_t r;
        r.command = cmd;
        r.mask = m;
        r.match_all = all;
        r.clear_on_match = clr;
        r.may_wait = wait_on_miss;
        r.task_id = tid;
        return r;
    endfunction

    function automatic logic [31:0] random_mask();
        logic [31:0] m;
        case ($urandom_range(5))
            0: m = '0;
            1: m = '1;
            2, 3:
            begin
                m = 32'h1 << $urandom_range(31);
                if ($urandom_range(1))
                    m |= 32'h1 << $urandom_range(31);
            end
            default: m = $urandom;
        endcase
        return m;
    endfunction

    task automatic add_request(input req_t r, input int unsigned gap, input bit drain);
        stim_item_t it;
        it.req = r;
        it.gap = gap;
        it.drain = drain;
        request_backlog.push_back(it);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // driver
    always @(posedge clk)
    begin : drive
        bit took;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            took = start && !busy;
            if (took)
                apply_flag_command(request);
            if (!start || took)
            begin
                if (!item_loaded && request_backlog.size() > 0)
                begin
                    now_item = request_backlog.pop_front();
                    item_loaded = 1'b1;
                    gap_left = now_item.gap;
                end
                if (!item_loaded)
                begin
                    start <= 1'b0;
                end
                else if (now_item.drain)
                begin
                    if (!took && results_due.size() == 0)
                        now_item.drain = 1'b0;
                    start <= 1'b0;
                end
                else if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else
                begin
                    request <= now_item.req;
                    start <= 1'b1;
                    item_loaded = 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && strobe)
        begin
            if (results_due.size() == 0)
            begin
                $error("unexpected result: flags_before %0h woken_valid %0b woken_task %0d",
                       result.flags_before, result.woken_valid, result.woken_task);
                fail_count++;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("flags_before", want.flags_before, result.flags_before);
                check_field("satisfied", 32'(want.satisfied), 32'(result.satisfied));
                check_field("queued", 32'(want.queued), 32'(result.queued));
                check_field("woken_valid", 32'(want.woken_valid), 32'(result.woken_valid));
                check_field("woken_task", 32'(want.woken_task), 32'(result.woken_task));
                check_field("last", 32'(want.last), 32'(result.last));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [31:0] m;
        bit          burst;
        logic [2:0]  cmd;
        int unsigned pick;

        // empty mask: any never holds, all always holds
        add_request(make_req(CMD_TEST, '0, 1'b0, 1'b0, 1'b0, 4'd0), 0, 1'b0);
        add_request(make_req(CMD_TEST, '0, 1'b1, 1'b1, 1'b0, 4'd1), 1, 1'b0);
        // fill every waiter slot, then release all of them at once
        for (int t = 0; t < SLOTS; t++)
        begin
            m = 32'h1 << (2 * t);
            if (t % 2 == 1)
                m |= 32'h2 << (2 * t);
            add_request(make_req(CMD_TEST, m, t % 2 == 1, 1'b1, 1'b1, 4'(t)),
                        $urandom_range(3), 1'b0);
        end
        add_request(make_req(CMD_SET, '1, 1'b0, 1'b0, 1'b0, 4'd0), 0, 1'b1);
        add_request(make_req(CMD_TEST, '1, 1'b1, 1'b1, 1'b0, 4'd2), 0, 1'b0);
        // overwrite of an occupied slot, toggle with and without release
        add_request(make_req(CMD_TEST, 32'h1, 1'b0, 1'b0, 1'b1, 4'd5), 0, 1'b0);
        add_request(make_req(CMD_TEST, 32'h2, 1'b0, 1'b0, 1'b1, 4'd5), 2, 1'b0);
        add_request(make_req(CMD_TOGGLE, 32'h1, 1'b0, 1'b0, 1'b0, 4'd5), 0, 1'b0);
        add_request(make_req(CMD_TOGGLE, 32'h2, 1'b0, 1'b0, 1'b0, 4'd5), 1, 1'b0);
        // cancel of an empty slot
        add_request(make_req(CMD_CANCEL, 32'h0, 1'b0, 1'b0, 1'b0, 4'd5), 0, 1'b0);
        add_request(make_req(CMD_CLEAR, '1, 1'b1, 1'b1, 1'b1, 4'd15), 3, 1'b0);
        add_request(make_req(CMD_UNDEF_LO, 32'hA5A5_5A5A, 1'b1, 1'b1, 1'b1, 4'd9), 0, 1'b0);

        burst = 1'b0;
        for (int k = 0; k < RANDOM_REQUESTS; k++)
        begin
            if (k % 40 == 0)
                burst = $urandom_range(2) == 0;
            pick = $urandom_range(99);
            if (pick < 40)
                cmd = CMD_TEST;
            else if (pick < 60)
                cmd = CMD_SET;
            else if (pick < 72)
                cmd = CMD_CLEAR;
            else if (pick < 86)
                cmd = CMD_TOGGLE;
            else if (pick < 96)
                cmd = CMD_CANCEL;
            else
                cmd = 3'($urandom_range(CMD_UNDEF_HI, CMD_UNDEF_LO));
            add_request(make_req(cmd, random_mask(), $urandom_range(1), $urandom_range(1),
                                 $urandom_range(6) != 0, 4'($urandom_range(SLOTS - 1))),
                        burst ? 0 : $urandom_range(3), $urandom_range(39) == 0);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (request_backlog.size() != 0 || item_loaded || start || results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
